// ===== design/sbqeq_pkg.sv =====
// shared types and constants of the stereo biquad cascade equalizer
`default_nettype none

package sbqeq_pkg;

   // fixed field widths
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 32;
   localparam int COEF_FRAC   = COEF_BITS - 5;
   localparam int HIST_BITS   = 32;
   localparam int PROD_BITS   = COEF_BITS + HIST_BITS;
   localparam int ACC_BITS    = PROD_BITS + 3;
   localparam int SLOTS       = 5;

   // item kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_COEF   = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // coefficient slots within one band
   localparam logic [2:0] SLOT_B0 = 3'd0;
   localparam logic [2:0] SLOT_B1 = 3'd1;
   localparam logic [2:0] SLOT_B2 = 3'd2;
   localparam logic [2:0] SLOT_A1 = 3'd3;
   localparam logic [2:0] SLOT_A2 = 3'd4;

   typedef struct packed {
      logic [1:0]                   kind;
      logic                         channel;
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic [5:0]                   coef_index;
      logic signed [COEF_BITS-1:0]  coef_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                         channel_out;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic       take_item;
      logic       coef_write;
      logic       hist_clear;
      logic       coef_re;
      logic       hist_re;
      logic [2:0] rd_slot;
      logic       mul_en;
      logic [2:0] mul_slot;
      logic       acc_clear;
      logic       acc_en;
      logic       acc_neg;
      logic       round_en;
      logic       hist_we;
      logic       out_load;
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/stereo_biquad_cascade_eq_unit.sv =====
// top level of the stereo biquad cascade equalizer
`default_nettype none

// Each filtered sample runs through BANDS direct-form-I biquad sections in
// turn, with one 32x32 multiplier and one coefficient memory read port shared
// by all five products of a section. A section steps through five coefficient
// reads, the multiplies and accumulates, a round and a history write. A sample
// that is not filtered (block disabled or channel out of range) passes
// through unchanged. A new item is taken while the previous result still
// waits in the output register. History clears are immediate: per-row
// written flags make cleared rows read as zero.
module stereo_biquad_cascade_eq_unit #(
   parameter int BANDS    = 8,
   parameter int CHANNELS = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire sbqeq_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output sbqeq_pkg::rsp_type      rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_data
);

   localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

   sbqeq_pkg::cmd_type cmd;
   logic [BW-1:0]      band;

   sbqeq_ctrl #(.BANDS(BANDS), .CHANNELS(CHANNELS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_data.kind),
      .req_channel (req_data.channel),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_enable  (csr_data),
      .cmd         (cmd),
      .band        (band)
   );

   sbqeq_dpath #(.BANDS(BANDS), .CHANNELS(CHANNELS)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .band     (band),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== design/sbqeq_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module sbqeq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 40,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, held when not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/sbqeq_ctrl.sv =====
// sequencer of the equalizer: handshakes, band and step schedule
`default_nettype none

module sbqeq_ctrl #(
   parameter int BANDS    = 8,
   parameter int CHANNELS = 2,
   localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_kind,
   input  wire logic               req_channel,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_enable,
   output sbqeq_pkg::cmd_type      cmd,
   output logic [BW-1:0]           band
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_DONE = 3'b100
   } state_type;

   localparam logic [3:0] STEP_MUL_LAST = 4'd5;
   localparam logic [3:0] STEP_ACC_LAST = 4'd6;
   localparam logic [3:0] STEP_ROUND    = 4'd7;
   localparam logic [3:0] STEP_WRITE    = 4'd8;

   state_type   state_ff, state_in;
   logic [BW-1:0] band_ff, band_in;
   logic [3:0]  step_ff, step_in;
   logic        enable_ff, enable_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accept;
   logic        filt;

   assign csr_ready = 1'b1;
   assign enable_in = (csr_valid && csr_ready) ? csr_enable : enable_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign filt      = enable_ff && (32'(req_channel) < CHANNELS);

   // state machine and step schedule
   always_comb begin
      state_in = state_ff;
      band_in  = band_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  sbqeq_pkg::KIND_SAMPLE: begin
                     cmd.take_item = 1'b1;
                     band_in  = '0;
                     step_in  = '0;
                     state_in = filt ? S_RUN : S_DONE;
                  end
                  sbqeq_pkg::KIND_COEF:  cmd.coef_write = 1'b1;
                  sbqeq_pkg::KIND_CLEAR: cmd.hist_clear = 1'b1;
                  default: ;
               endcase
            end
         end
         S_RUN: begin
            cmd.coef_re   = (step_ff <= 4'd4);
            cmd.rd_slot   = step_ff[2:0];
            cmd.hist_re   = (step_ff == 4'd0);
            cmd.mul_en    = (step_ff >= 4'd1) && (step_ff <= STEP_MUL_LAST);
            cmd.mul_slot  = 3'(step_ff - 4'd1);
            cmd.acc_clear = (step_ff == 4'd0);
            cmd.acc_en    = (step_ff >= 4'd2) && (step_ff <= STEP_ACC_LAST);
            cmd.acc_neg   = (step_ff == STEP_MUL_LAST) || (step_ff == STEP_ACC_LAST);
            cmd.round_en  = (step_ff == STEP_ROUND);
            cmd.hist_we   = (step_ff == STEP_WRITE);
            step_in = step_ff + 4'd1;
            if (step_ff == STEP_WRITE) begin
               step_in = '0;
               if (band_ff == BW'(BANDS - 1)) begin
                  state_in = S_DONE;
               end else begin
                  band_in = band_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         band_ff      <= '0;
         step_ff      <= '0;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         band_ff      <= band_in;
         step_ff      <= step_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign band      = band_ff;

   // a result is loaded only into a free or draining output register
   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending item");

   // step counter stays within one band schedule
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_WRITE)
      else $error("step counter out of range");

   // a filtered sample starts the cascade at band zero
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == sbqeq_pkg::KIND_SAMPLE && filt)
         |=> (state_ff == S_RUN && band_ff == '0 && step_ff == 4'd0))
      else $error("filtered sample did not start the cascade");

endmodule

`default_nettype wire

// ===== design/sbqeq_dpath.sv =====
// datapath: coefficient and history memories, shared multiplier, accumulator
`default_nettype none

module sbqeq_dpath #(
   parameter int BANDS    = 8,
   parameter int CHANNELS = 2,
   localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sbqeq_pkg::cmd_type cmd,
   input  wire logic [BW-1:0]      band,
   input  wire sbqeq_pkg::req_type req_data,
   output sbqeq_pkg::rsp_type      rsp_data
);

   localparam int COEF_DEPTH = BANDS * sbqeq_pkg::SLOTS;
   localparam int ROWS       = BANDS * CHANNELS;
   localparam int CAW  = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
   localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int HB   = sbqeq_pkg::HIST_BITS;
   localparam int CB   = sbqeq_pkg::COEF_BITS;
   localparam int PB   = sbqeq_pkg::PROD_BITS;
   localparam int AB   = sbqeq_pkg::ACC_BITS;
   localparam int SB   = sbqeq_pkg::SAMPLE_BITS;
   localparam int FRAC = sbqeq_pkg::COEF_FRAC;
   localparam int SHB  = AB - FRAC;
   localparam logic signed [AB-1:0]  HALF    = AB'(1) <<< (FRAC - 1);
   localparam logic signed [SHB-1:0] Y_MAX   = SHB'((64'sd1 <<< (HB - 1)) - 1);
   localparam logic signed [SHB-1:0] Y_MIN   = -Y_MAX - SHB'(1);
   localparam logic signed [HB-1:0]  OUT_MAX = HB'((64'sd1 <<< (SB - 1)) - 1);
   localparam logic signed [HB-1:0]  OUT_MIN = -OUT_MAX - HB'(1);

   logic signed [HB-1:0] x_ff, x_in;
   logic                 ch_ff;
   logic signed [PB-1:0] prod_ff;
   logic signed [AB-1:0] acc_ff;
   logic signed [HB-1:0] y_ff;
   logic [COEF_DEPTH-1:0] coef_vld_ff;
   logic [ROWS-1:0]      hist_vld_ff;
   logic                 coef_vq_ff;
   logic                 hist_vq_ff;
   sbqeq_pkg::rsp_type   rsp_ff;

   logic [7:0]           idx_ext;
   logic                 coef_we;
   logic [CAW-1:0]       coef_waddr;
   logic [CAW-1:0]       coef_raddr;
   logic [7:0]           coef_raddr_full;
   logic [CB-1:0]        coef_rdata;
   logic [RAW-1:0]       row;
   logic [7:0]           row_full;
   logic [4*HB-1:0]      hist_rdata;
   logic [4*HB-1:0]      hist_wdata;
   logic signed [CB-1:0] coef_op;
   logic signed [HB-1:0] x1, x2, y1, y2, hist_op;
   logic signed [AB-1:0] prod_ext;
   logic signed [AB-1:0] sum;
   logic signed [SHB-1:0] shifted;
   logic signed [HB-1:0] y_sat;
   logic signed [HB-1:0] out_sat;

   // coefficient write address, out-of-range indexes are dropped
   assign idx_ext    = {2'b00, req_data.coef_index};
   assign coef_we    = cmd.coef_write && (32'(idx_ext) < COEF_DEPTH);
   assign coef_waddr = idx_ext[CAW-1:0];

   // read addresses for the current band
   assign coef_raddr_full = 8'(band) * 8'(sbqeq_pkg::SLOTS) + 8'(cmd.rd_slot);
   assign coef_raddr      = coef_raddr_full[CAW-1:0];
   assign row_full        = 8'(band) * 8'(CHANNELS) + 8'(ch_ff);
   assign row             = row_full[RAW-1:0];

   sbqeq_ram #(.WIDTH(CB), .DEPTH(COEF_DEPTH)) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr (coef_waddr),
      .wdata (req_data.coef_value),
      .re    (cmd.coef_re),
      .raddr (coef_raddr),
      .rdata (coef_rdata)
   );

   sbqeq_ram #(.WIDTH(4 * HB), .DEPTH(ROWS)) u_hist_ram (
      .clock (clock),
      .we    (cmd.hist_we),
      .waddr (row),
      .wdata (hist_wdata),
      .re    (cmd.hist_re),
      .raddr (row),
      .rdata (hist_rdata)
   );

   // never-written entries read as zero
   assign coef_op = coef_vq_ff ? $signed(coef_rdata) : '0;
   assign x1 = hist_vq_ff ? $signed(hist_rdata[4*HB-1:3*HB]) : '0;
   assign x2 = hist_vq_ff ? $signed(hist_rdata[3*HB-1:2*HB]) : '0;
   assign y1 = hist_vq_ff ? $signed(hist_rdata[2*HB-1:HB])   : '0;
   assign y2 = hist_vq_ff ? $signed(hist_rdata[HB-1:0])      : '0;

   // shift the history row: new x1 is the band input, new y1 the band output
   assign hist_wdata = {x_ff, x1, y_ff, y1};

   // multiplier operand select
   always_comb begin
      case (cmd.mul_slot)
         sbqeq_pkg::SLOT_B0: hist_op = x_ff;
         sbqeq_pkg::SLOT_B1: hist_op = x1;
         sbqeq_pkg::SLOT_B2: hist_op = x2;
         sbqeq_pkg::SLOT_A1: hist_op = y1;
         default:            hist_op = y2;
      endcase
   end

   // round to nearest, ties up, then saturate to the history width
   assign prod_ext = AB'(prod_ff);
   assign sum      = acc_ff + HALF;
   assign shifted  = SHB'(sum >>> FRAC);
   always_comb begin
      if (shifted > Y_MAX) begin
         y_sat = Y_MAX[HB-1:0];
      end else if (shifted < Y_MIN) begin
         y_sat = Y_MIN[HB-1:0];
      end else begin
         y_sat = shifted[HB-1:0];
      end
   end

   // output saturation to the sample width
   always_comb begin
      if (x_ff > OUT_MAX) begin
         out_sat = OUT_MAX;
      end else if (x_ff < OUT_MIN) begin
         out_sat = OUT_MIN;
      end else begin
         out_sat = x_ff;
      end
   end

   // band input: loaded from the item, then replaced by each band output
   always_comb begin
      x_in = x_ff;
      if (cmd.take_item) begin
         x_in = HB'(req_data.sample_in);
      end else if (cmd.hist_we) begin
         x_in = y_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (cmd.take_item) begin
         ch_ff <= req_data.channel;
      end
      if (cmd.mul_en) begin
         prod_ff <= coef_op * hist_op;
      end
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= cmd.acc_neg ? acc_ff - prod_ext : acc_ff + prod_ext;
      end
      if (cmd.round_en) begin
         y_ff <= y_sat;
      end
      if (cmd.coef_re) begin
         coef_vq_ff <= coef_vld_ff[coef_raddr];
      end
      if (cmd.hist_re) begin
         hist_vq_ff <= hist_vld_ff[row];
      end
      if (cmd.out_load) begin
         rsp_ff.sample_out  <= out_sat[SB-1:0];
         rsp_ff.channel_out <= ch_ff;
      end
   end

   // written-entry flags
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
         hist_vld_ff <= '0;
      end else begin
         if (coef_we) begin
            coef_vld_ff[coef_waddr] <= 1'b1;
         end
         if (cmd.hist_clear) begin
            hist_vld_ff <= '0;
         end else if (cmd.hist_we) begin
            hist_vld_ff[row] <= 1'b1;
         end
      end
   end

   assign rsp_data = rsp_ff;

   // a clear never coincides with a history write
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      !(cmd.hist_clear && cmd.hist_we))
      else $error("history clear during a band write");

   // a written history row reads back as valid
   a_row_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.hist_we |=> hist_vld_ff[$past(row)])
      else $error("history row flag not set");

   // a coefficient write marks its entry
   a_coef_valid: assert property (@(posedge clock) disable iff (reset)
      coef_we |=> coef_vld_ff[$past(coef_waddr)])
      else $error("coefficient flag not set");

endmodule

`default_nettype wire
